// File: rtl/core/pds_pkg.sv
`timescale 1ns / 1ps
package pds_pkg;

    localparam int EW  = 11;  // element and node value width
    localparam int AW  = 2;   // action code width
    localparam int TVW = 12;  // target version field width

    localparam logic [AW-1:0] ACT_UNION  = 2'd0;
    localparam logic [AW-1:0] ACT_REVERT = 2'd1;
    localparam logic [AW-1:0] ACT_QUERY  = 2'd2;
    localparam logic [AW-1:0] ACT_NOP    = 2'd3;

    typedef struct packed {
        logic [AW-1:0]  action;
        logic [EW-1:0]  elem_a;
        logic [EW-1:0]  elem_b;
        logic [TVW-1:0] target_version;
    } t_in;

    typedef struct packed {
        logic same_set;
        logic overflow;
    } t_out;

    typedef struct packed {
        logic init;
        logic step;
    } t_rng_ctl;

endpackage

// File: rtl/core/pds_range.sv
`timescale 1ns / 1ps
// Bisection walker over [1, total]: one halving compare per step.
module pds_range (
    input  logic                   i_clk,
    input  pds_pkg::t_rng_ctl      i_ctl,
    input  logic [pds_pkg::EW-1:0] i_elem,
    input  logic [pds_pkg::EW-1:0] i_total,
    output logic [pds_pkg::EW-1:0] o_lo,
    output logic                   o_leaf,
    output logic                   o_left
);
    logic [pds_pkg::EW-1:0] r_lo, r_hi;
    logic [pds_pkg::EW:0]   sum;
    logic [pds_pkg::EW-1:0] mid;

    assign sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid    = sum[pds_pkg::EW:1];
    assign o_lo   = r_lo;
    assign o_leaf = (r_lo == r_hi);
    assign o_left = (i_elem <= mid);

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_lo <= {{(pds_pkg::EW-1){1'b0}}, 1'b1};
            r_hi <= i_total;
        end else if (i_ctl.step) begin
            if (o_left) begin
                r_hi <= mid;
            end else begin
                r_lo <= mid + {{(pds_pkg::EW-1){1'b0}}, 1'b1};
            end
        end
    end
endmodule

// File: rtl/core/pds_pool.sv
`timescale 1ns / 1ps
// Node pool: left/right child pointers and node value, one write and one read port.
module pds_pool #(
    parameter int PW   = 17,
    parameter int PTRW = 18
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [PW-1:0]          i_waddr,
    input  logic [PTRW-1:0]        i_wl,
    input  logic [PTRW-1:0]        i_wr,
    input  logic [pds_pkg::EW-1:0] i_wv,
    input  logic [PW-1:0]          i_raddr,
    output logic [PTRW-1:0]        o_rl,
    output logic [PTRW-1:0]        o_rr,
    output logic [pds_pkg::EW-1:0] o_rv
);
    logic [PTRW-1:0]        mem_l [2**PW];
    logic [PTRW-1:0]        mem_r [2**PW];
    logic [pds_pkg::EW-1:0] mem_v [2**PW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_l[i_waddr] <= i_wl;
            mem_r[i_waddr] <= i_wr;
            mem_v[i_waddr] <= i_wv;
        end
        o_rl <= mem_l[i_raddr];
        o_rr <= mem_r[i_raddr];
        o_rv <= mem_v[i_raddr];
    end
endmodule

// File: rtl/core/pds_vtab.sv
`timescale 1ns / 1ps
// Per-version root pair table.
module pds_vtab #(
    parameter int VW   = 12,
    parameter int PTRW = 18
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [VW-1:0]   i_waddr,
    input  logic [PTRW-1:0] i_wp,
    input  logic [PTRW-1:0] i_ws,
    input  logic [VW-1:0]   i_raddr,
    output logic [PTRW-1:0] o_rp,
    output logic [PTRW-1:0] o_rs
);
    logic [PTRW-1:0] mem_p [2**VW];
    logic [PTRW-1:0] mem_s [2**VW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_p[i_waddr] <= i_wp;
            mem_s[i_waddr] <= i_ws;
        end
        o_rp <= mem_p[i_raddr];
        o_rs <= mem_s[i_raddr];
    end
endmodule

// File: rtl/core/persistent_disjoint_set.sv
`timescale 1ns / 1ps
// Versioned union-find engine (union by size over path-copied segment trees).
// Input channel: i_in_valid / o_in_stall carry one t_in transaction (action,
// elem_a, elem_b, target_version). Output channel: o_out_valid / i_out_stall
// carry one t_out transaction (same_set, overflow) per input transaction.
// One transaction is worked at a time; o_in_stall is high until it retires.
// Cost: a leaf lookup walks D = ceil(log2 n) tree levels with at most one pool
// read each; a root search is (hops+1) lookups; a union adds two size lookups,
// a path count over both trees and a path copy into each of the two trees.
// All of these share the one pool read port and the single bisection walker.
// Reset, or a write on i_cfg_we, rebuilds version 0: the initial trees are
// implicit, so no pool sweep is needed. The result sits in an output register;
// while the receiver stalls it holds, and the next transaction is taken as soon
// as the finishing one has been handed to that register.
module persistent_disjoint_set #(
    parameter int MAX_ELEMS    = 1024,
    parameter int MAX_VERSIONS = 4096,
    parameter int POOL_NODES   = 131072
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [pds_pkg::EW-1:0] i_cfg_data,
    input  logic                   i_in_valid,
    input  pds_pkg::t_in           i_in_data,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output pds_pkg::t_out          o_out_data,
    input  logic                   i_out_stall
);
    localparam int PW   = $clog2(POOL_NODES);
    localparam int PTRW = PW + 1;
    localparam int VW   = $clog2(MAX_VERSIONS);
    localparam int EW   = pds_pkg::EW;
    localparam int NCAP = (MAX_ELEMS < POOL_NODES / 4) ? MAX_ELEMS : POOL_NODES / 4;
    // pointer with top bit set: untouched initial subtree
    localparam logic [PTRW-1:0] IMPL = {1'b1, {PW{1'b0}}};

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RVRD  = 4'd2;
    localparam logic [3:0] S_RVDAT = 4'd3;
    localparam logic [3:0] S_LINIT = 4'd4;
    localparam logic [3:0] S_LSTEP = 4'd5;
    localparam logic [3:0] S_LCH   = 4'd6;
    localparam logic [3:0] S_LVAL  = 4'd7;
    localparam logic [3:0] S_LRET  = 4'd8;
    localparam logic [3:0] S_CINIT = 4'd9;
    localparam logic [3:0] S_CSTEP = 4'd10;
    localparam logic [3:0] S_CHK   = 4'd11;
    localparam logic [3:0] S_PINIT = 4'd12;
    localparam logic [3:0] S_PRD   = 4'd13;
    localparam logic [3:0] S_PWR   = 4'd14;
    localparam logic [3:0] S_FIN   = 4'd15;

    localparam logic [1:0] PH_FA = 2'd0;
    localparam logic [1:0] PH_FB = 2'd1;
    localparam logic [1:0] PH_SA = 2'd2;
    localparam logic [1:0] PH_SB = 2'd3;

    logic [3:0]              r_state;
    logic [1:0]              r_ph;
    logic [pds_pkg::AW-1:0]  r_act;
    logic [EW-1:0]           r_a, r_b, r_count, r_n, r_x, r_p;
    logic [EW-1:0]           r_fa, r_fb, r_sa, r_sb, r_big, r_small, r_pv;
    logic [pds_pkg::TVW-1:0] r_tgt;
    logic [PW:0]             r_nf;
    logic [VW-1:0]           r_cv;
    logic [PTRW-1:0]         r_pr, r_sr, r_npr, r_nsr, r_k;
    logic [11:0]             r_guard;
    logic [5:0]              r_cnt;
    logic                    r_pass, r_sz, r_same, r_ovf;
    logic                    r_ovalid;
    pds_pkg::t_out           r_odata;

    pds_pkg::t_rng_ctl rng_ctl;
    logic [EW-1:0]     rng_lo;
    logic              rng_leaf, rng_left;

    logic [PTRW-1:0] p_rl, p_rr;
    logic [EW-1:0]   p_rv;
    logic            p_we;
    logic [PTRW-1:0] p_wl, p_wr, o_l, o_r, child;
    logic [EW-1:0]   p_wv, o_v;

    logic            v_we;
    logic [VW-1:0]   v_waddr, v_raddr;
    logic [PTRW-1:0] v_wp, v_ws, v_rp, v_rs;

    logic            full, out_free;
    logic [EW-1:0]   n_tot, ca, cb, cp, sum_sz;
    logic [31:0]     cnt32, tgt32, cv32, nf_need;
    logic [PW:0]     nf_init;

    function automatic logic [EW-1:0] clamp_e(input logic [EW-1:0] e, input logic [EW-1:0] n);
        logic [EW-1:0] t;
        t = (e == '0) ? {{(EW-1){1'b0}}, 1'b1} : e;
        if (t > n) t = n;
        return t;
    endfunction

    pds_range u_range (
        .i_clk   (i_clk),
        .i_ctl   (rng_ctl),
        .i_elem  (r_x),
        .i_total (r_n),
        .o_lo    (rng_lo),
        .o_leaf  (rng_leaf),
        .o_left  (rng_left)
    );

    pds_pool #(.PW(PW), .PTRW(PTRW)) u_pool (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (r_nf[PW-1:0]),
        .i_wl    (p_wl),
        .i_wr    (p_wr),
        .i_wv    (p_wv),
        .i_raddr (r_k[PW-1:0]),
        .o_rl    (p_rl),
        .o_rr    (p_rr),
        .o_rv    (p_rv)
    );

    pds_vtab #(.VW(VW), .PTRW(PTRW)) u_vtab (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wp    (v_wp),
        .i_ws    (v_ws),
        .i_raddr (v_raddr),
        .o_rp    (v_rp),
        .o_rs    (v_rs)
    );

    always_comb begin
        cnt32 = {{(32-EW){1'b0}}, r_count};
        if (cnt32 == 32'd0) cnt32 = 32'd1;
        if (cnt32 > NCAP) cnt32 = NCAP;
        n_tot = cnt32[EW-1:0];
    end

    assign nf_init  = PTRW'(({21'd0, n_tot} << 2) - 32'd2);
    assign full     = ({{(32-VW){1'b0}}, r_cv} + 32'd1) >= MAX_VERSIONS;
    assign out_free = !r_ovalid || !i_out_stall;
    assign ca       = clamp_e(i_in_data.elem_a, r_n);
    assign cb       = clamp_e(i_in_data.elem_b, r_n);
    assign cp       = clamp_e(r_p, r_n);
    assign sum_sz   = r_sa + r_sb;
    assign tgt32    = {{(32-pds_pkg::TVW){1'b0}}, i_in_data.target_version};
    assign cv32     = {{(32-VW){1'b0}}, r_cv};
    assign nf_need  = {{(31-PW){1'b0}}, r_nf} + {26'd0, r_cnt};
    assign v_raddr  = VW'({20'd0, r_tgt});

    // old node as seen by the path copy; an implicit node has implicit children
    assign o_l   = r_k[PW] ? IMPL : p_rl;
    assign o_r   = r_k[PW] ? IMPL : p_rr;
    assign o_v   = r_k[PW] ? '0 : p_rv;
    assign child = {1'b0, PW'(r_nf[PW-1:0] + 1'b1)};

    always_comb begin
        p_we = (r_state == S_PWR);
        p_wl = o_l;
        p_wr = o_r;
        p_wv = rng_leaf ? r_pv : o_v;
        if (!rng_leaf) begin
            if (rng_left) p_wl = child;
            else          p_wr = child;
        end
    end

    always_comb begin
        v_we    = 1'b0;
        v_waddr = r_cv + 1'b1;
        v_wp    = r_npr;
        v_ws    = r_nsr;
        if (r_state == S_INIT) begin
            v_we    = 1'b1;
            v_waddr = '0;
            v_wp    = IMPL;
            v_ws    = IMPL;
        end else if (r_state == S_FIN && out_free && !full) begin
            v_we = 1'b1;
        end
    end

    always_comb begin
        rng_ctl.init = (r_state == S_LINIT) || (r_state == S_CINIT) || (r_state == S_PINIT);
        rng_ctl.step = !rng_leaf && (((r_state == S_LSTEP) && r_k[PW]) ||
                       (r_state == S_LCH) || (r_state == S_CSTEP) || (r_state == S_PWR));
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_count  <= EW'(1024);
            r_ovalid <= 1'b0;
        end else begin
            // the finishing state refills the output register itself
            if (r_ovalid && !i_out_stall && !(r_state == S_FIN && !i_cfg_we)) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
                r_state <= S_INIT;
            end else begin
                unique case (r_state)
                    S_INIT: begin
                        r_n     <= n_tot;
                        r_nf    <= nf_init;
                        r_cv    <= '0;
                        r_pr    <= IMPL;
                        r_sr    <= IMPL;
                        r_state <= S_IDLE;
                    end
                    S_IDLE: begin
                        if (i_in_valid) begin
                            r_act   <= i_in_data.action;
                            r_a     <= ca;
                            r_b     <= cb;
                            r_tgt   <= i_in_data.target_version;
                            r_ovf   <= full;
                            r_same  <= 1'b0;
                            r_npr   <= r_pr;
                            r_nsr   <= r_sr;
                            r_x     <= ca;
                            r_k     <= r_pr;
                            r_sz    <= 1'b0;
                            r_guard <= '0;
                            r_ph    <= PH_FA;
                            if (i_in_data.action == pds_pkg::ACT_QUERY) begin
                                r_state <= S_LINIT;
                            end else if (full || i_in_data.action == pds_pkg::ACT_NOP) begin
                                r_state <= S_FIN;
                            end else if (i_in_data.action == pds_pkg::ACT_REVERT) begin
                                if (tgt32 <= cv32 && tgt32 < MAX_VERSIONS) begin
                                    r_state <= S_RVRD;
                                end else begin
                                    r_ovf   <= 1'b1;
                                    r_state <= S_FIN;
                                end
                            end else begin
                                r_state <= S_LINIT;
                            end
                        end
                    end
                    S_RVRD: r_state <= S_RVDAT;
                    S_RVDAT: begin
                        r_npr   <= v_rp;
                        r_nsr   <= v_rs;
                        r_state <= S_FIN;
                    end
                    S_LINIT: r_state <= S_LSTEP;
                    S_LSTEP: begin
                        if (rng_leaf) begin
                            if (r_k[PW]) begin
                                r_p     <= r_sz ? {{(EW-1){1'b0}}, 1'b1} : rng_lo;
                                r_state <= S_LRET;
                            end else begin
                                r_state <= S_LVAL;
                            end
                        end else if (!r_k[PW]) begin
                            r_state <= S_LCH;
                        end
                    end
                    S_LCH: begin
                        r_k     <= rng_left ? p_rl : p_rr;
                        r_state <= S_LSTEP;
                    end
                    S_LVAL: begin
                        r_p     <= p_rv;
                        r_state <= S_LRET;
                    end
                    S_LRET: begin
                        r_state <= S_LINIT;
                        unique case (r_ph)
                            PH_FA, PH_FB: begin
                                if (r_x != r_p && {1'b0, r_guard} <= {2'b0, r_n}) begin
                                    r_x     <= cp;
                                    r_guard <= r_guard + 1'b1;
                                    r_k     <= r_pr;
                                end else if (r_ph == PH_FA) begin
                                    r_fa    <= r_x;
                                    r_x     <= r_b;
                                    r_k     <= r_pr;
                                    r_guard <= '0;
                                    r_ph    <= PH_FB;
                                end else begin
                                    r_fb <= r_x;
                                    if (r_act == pds_pkg::ACT_QUERY) begin
                                        r_same  <= (r_fa == r_x);
                                        r_state <= S_FIN;
                                    end else if (r_fa == r_x) begin
                                        r_state <= S_FIN;
                                    end else begin
                                        r_x  <= r_fa;
                                        r_k  <= r_sr;
                                        r_sz <= 1'b1;
                                        r_ph <= PH_SA;
                                    end
                                end
                            end
                            PH_SA: begin
                                r_sa <= r_p;
                                r_x  <= r_fb;
                                r_k  <= r_sr;
                                r_ph <= PH_SB;
                            end
                            PH_SB: begin
                                // ties keep elem_a's root on top
                                r_sb <= r_p;
                                if (r_sa < r_p) begin
                                    r_big   <= r_fb;
                                    r_small <= r_fa;
                                    r_x     <= r_fa;
                                end else begin
                                    r_big   <= r_fa;
                                    r_small <= r_fb;
                                    r_x     <= r_fb;
                                end
                                r_cnt   <= '0;
                                r_pass  <= 1'b0;
                                r_state <= S_CINIT;
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                    S_CINIT: r_state <= S_CSTEP;
                    S_CSTEP: begin
                        r_cnt <= r_cnt + 1'b1;
                        if (rng_leaf) begin
                            if (!r_pass) begin
                                r_pass  <= 1'b1;
                                r_x     <= r_big;
                                r_state <= S_CINIT;
                            end else begin
                                r_state <= S_CHK;
                            end
                        end
                    end
                    S_CHK: begin
                        if (nf_need > POOL_NODES) begin
                            r_ovf   <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_x     <= r_small;
                            r_k     <= r_pr;
                            r_pv    <= r_big;
                            r_pass  <= 1'b0;
                            r_state <= S_PINIT;
                        end
                    end
                    S_PINIT: begin
                        if (!r_pass) r_npr <= {1'b0, r_nf[PW-1:0]};
                        else         r_nsr <= {1'b0, r_nf[PW-1:0]};
                        r_state <= S_PRD;
                    end
                    S_PRD: r_state <= S_PWR;
                    S_PWR: begin
                        r_nf <= r_nf + 1'b1;
                        if (rng_leaf) begin
                            if (!r_pass) begin
                                r_pass  <= 1'b1;
                                r_x     <= r_big;
                                r_k     <= r_sr;
                                r_pv    <= sum_sz;
                                r_state <= S_PINIT;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end else begin
                            r_k     <= rng_left ? o_l : o_r;
                            r_state <= S_PRD;
                        end
                    end
                    S_FIN: begin
                        if (out_free) begin
                            r_ovalid         <= 1'b1;
                            r_odata.same_set <= r_same;
                            r_odata.overflow <= r_ovf;
                            if (!full) begin
                                r_cv <= r_cv + 1'b1;
                                r_pr <= r_npr;
                                r_sr <= r_nsr;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                    default: r_state <= S_INIT;
                endcase
            end
        end
    end
endmodule
